// File: src/u8d_pkg.sv
// shared types and constants for the utf-8 stream decoder with running totals
package u8d_pkg;

  // running total width default and fixed field widths
  localparam int CountWidthDef = 48;
  localparam int TotalWidth    = 48;
  localparam int CpWidth       = 21;

  // lead and continuation byte classes
  localparam logic [7:0] AsciiMask  = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'he0;
  localparam logic [7:0] Lead2Code  = 8'hc0;
  localparam logic [7:0] Lead3Mask  = 8'hf0;
  localparam logic [7:0] Lead3Code  = 8'he0;
  localparam logic [7:0] Lead4Mask  = 8'hf8;
  localparam logic [7:0] Lead4Code  = 8'hf0;
  localparam logic [7:0] Lead4Max   = 8'hf4;
  localparam logic [7:0] ContMask   = 8'hc0;
  localparam logic [7:0] ContCode   = 8'h80;
  localparam logic [7:0] ContBits   = 8'h3f;
  localparam logic [7:0] Lead2Bits  = 8'h1f;
  localparam logic [7:0] Lead3Bits  = 8'h0f;
  localparam logic [7:0] Lead4Bits  = 8'h07;

  // surrogate range
  localparam logic [CpWidth-1:0] SurrLow  = 21'h00d800;
  localparam logic [CpWidth-1:0] SurrHigh = 21'h00dfff;

  // continuation bytes still expected
  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendOne  = 2'd1;
  localparam logic [1:0] PendTwo  = 2'd2;
  localparam logic [1:0] PendThree = 2'd3;

  // input transfer payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } u8d_in_t;

  // result transfer payload
  typedef struct packed {
    logic [CpWidth-1:0]    code_point;
    logic                  is_error;
    logic [TotalWidth-1:0] valid_total;
    logic [TotalWidth-1:0] error_total;
    logic                  buffer_done;
  } u8d_out_t;

  // per-byte outcome from the decoder to counters and result register
  typedef struct packed {
    logic               emit;
    logic               err;
    logic [CpWidth-1:0] cp;
    logic               done;
  } u8d_step_t;

endpackage

// File: src/u8d_decode.sv
// byte-at-a-time utf-8 sequence decoder with open-sequence state
module u8d_decode
  import u8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  u8d_in_t   in_item,
  output u8d_step_t step
);

  logic [1:0]         pend_r, pend_nxt;
  logic [CpWidth-1:0] part_r, part_nxt;
  logic               bad_r, bad_nxt;

  logic [7:0]         b;
  logic               last;
  logic               open;
  logic               bad_seq;
  logic [CpWidth-1:0] part_shift;
  logic [1:0]         pend_dec;
  logic [7:0]         lead_bits;

  assign b    = in_item.data_byte;
  assign last = in_item.end_of_buffer;

  // next state and step outcome
  always_comb begin
    pend_nxt   = pend_r;
    part_nxt   = part_r;
    bad_nxt    = bad_r;
    open       = 1'b0;
    step       = '0;
    step.done  = last;
    bad_seq    = bad_r || ((b & ContMask) != ContCode);
    part_shift = {part_r[CpWidth-7:0], b[5:0]};
    pend_dec   = pend_r - 2'd1;
    lead_bits  = '0;
    if (fire) begin
      if (pend_r == PendNone) begin
        if ((b & AsciiMask) == 8'h00) begin
          step.emit = 1'b1;
          step.cp   = {{(CpWidth-8){1'b0}}, b};
        end else if ((b & Lead2Mask) == Lead2Code) begin
          lead_bits = b & Lead2Bits;
          pend_nxt  = PendOne;
          part_nxt  = {{(CpWidth-8){1'b0}}, lead_bits};
          bad_nxt   = 1'b0;
          open      = 1'b1;
        end else if ((b & Lead3Mask) == Lead3Code) begin
          lead_bits = b & Lead3Bits;
          pend_nxt  = PendTwo;
          part_nxt  = {{(CpWidth-8){1'b0}}, lead_bits};
          bad_nxt   = 1'b0;
          open      = 1'b1;
        end else if (((b & Lead4Mask) == Lead4Code) && (b <= Lead4Max)) begin
          lead_bits = b & Lead4Bits;
          pend_nxt  = PendThree;
          part_nxt  = {{(CpWidth-8){1'b0}}, lead_bits};
          bad_nxt   = 1'b0;
          open      = 1'b1;
        end else begin
          // bad lead byte skipped alone
          step.emit = 1'b1;
          step.err  = 1'b1;
        end
      end else if (pend_dec == PendNone) begin
        // sequence completes on this byte
        step.emit = 1'b1;
        step.err  = bad_seq || ((part_shift >= SurrLow) && (part_shift <= SurrHigh));
        step.cp   = step.err ? '0 : part_shift;
        pend_nxt  = PendNone;
        part_nxt  = '0;
        bad_nxt   = 1'b0;
      end else begin
        pend_nxt = pend_dec;
        part_nxt = part_shift;
        bad_nxt  = bad_seq;
        open     = 1'b1;
      end
      // sequence cut off by the end marker
      if (open && last) begin
        pend_nxt  = PendNone;
        part_nxt  = '0;
        bad_nxt   = 1'b0;
        step.emit = 1'b1;
        step.err  = 1'b1;
        step.cp   = '0;
      end
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PendNone;
      part_r <= '0;
      bad_r  <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
      bad_r  <= bad_nxt;
    end
  end

  // end marker always closes the sequence and yields a result
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last |=> pend_r == PendNone)
    else $error("sequence left open after end marker");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last |-> step.emit)
    else $error("end marker byte gave no result");

endmodule

// File: src/u8d_count.sv
// running totals of valid code points and errors
module u8d_count
  import u8d_pkg::*;
#(
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  u8d_step_t             step,
  output logic [TotalWidth-1:0] valid_total,
  output logic [TotalWidth-1:0] error_total
);

  localparam int ExtWidth = (COUNT_WIDTH > TotalWidth) ? COUNT_WIDTH : TotalWidth;

  logic [COUNT_WIDTH-1:0] valid_r, valid_nxt;
  logic [COUNT_WIDTH-1:0] error_r, error_nxt;
  logic [ExtWidth-1:0]    valid_ext, error_ext;

  // increment on each emitted result
  always_comb begin
    valid_nxt = valid_r;
    error_nxt = error_r;
    if (fire && step.emit) begin
      if (step.err) begin
        error_nxt = error_r + 1'b1;
      end else begin
        valid_nxt = valid_r + 1'b1;
      end
    end
  end

  // totals after this result, shown at the fixed output width
  always_comb begin
    valid_ext                  = '0;
    error_ext                  = '0;
    valid_ext[COUNT_WIDTH-1:0] = valid_nxt;
    error_ext[COUNT_WIDTH-1:0] = error_nxt;
  end

  assign valid_total = valid_ext[TotalWidth-1:0];
  assign error_total = error_ext[TotalWidth-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      error_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      error_r <= error_nxt;
    end
  end

  a_valid_inc: assert property (@(posedge clk) disable iff (!rst_n)
    fire && step.emit && !step.err |=>
      valid_r == COUNT_WIDTH'($past(valid_r) + 1'b1) && $stable(error_r))
    else $error("valid total did not step by one");

endmodule

// File: src/utf8_stream_decoder_counter.sv
// utf-8 stream decoder with running totals: input register, decode, result register
// each accepted byte is decoded from the input register into the result register
// one byte per cycle when not stalled; the result register parts the two channels
// a byte that leaves a sequence open gives no result
// reset: synchronous active-low rst_n clears the open sequence, totals and both stages
module utf8_stream_decoder_counter
  import u8d_pkg::*;
#(
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  u8d_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output u8d_out_t out_data
);

  logic      s1_valid_r, s1_valid_nxt;
  u8d_in_t   s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  u8d_out_t  out_data_r;
  logic      adv;
  logic      s1_fire;
  logic      in_xfer;
  u8d_step_t step;
  logic [TotalWidth-1:0] valid_total, error_total;

  // pipeline handshake
  assign adv      = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? (s1_fire && step.emit) : out_valid_r;

  u8d_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .in_item (s1_data_r),
    .step    (step)
  );

  u8d_count #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_count (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_fire),
    .step        (step),
    .valid_total (valid_total),
    .error_total (error_total)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (adv && s1_fire) begin
      out_data_r.code_point  <= step.cp;
      out_data_r.is_error    <= step.err;
      out_data_r.valid_total <= valid_total;
      out_data_r.error_total <= error_total;
      out_data_r.buffer_done <= step.done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !(s1_valid_r && step.emit) |=> !out_valid_r)
    else $error("result repeated after transfer");

endmodule
